>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ksc_pkg.sv
// ----------------------------------------------------------------------------
// ksc_pkg
// Types and constants shared by the KSC decoder and its result queue.
// ----------------------------------------------------------------------------
package ksc_pkg;

    // Result queue depth: room for the results of two items in flight.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_IW    = $clog2(OQ_DEPTH);

    // One result item as it waits in the queue.
    typedef struct packed {
        logic [15:0] char_code;
        logic        is_final;
        logic [1:0]  status;
        logic [15:0] bytes_converted;
    } t_res_item;

    // One optional push into the result queue.
    typedef struct packed {
        logic      valid;
        t_res_item item;
    } t_push;

endpackage

>>> sv/ksc_out_queue.sv
// ----------------------------------------------------------------------------
// ksc_out_queue
// Small result queue: takes up to two items a cycle, hands out one.
// ----------------------------------------------------------------------------
module ksc_out_queue
    import ksc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_push         i_push0,
    input  t_push         i_push1,
    input  logic          i_pop,
    output t_res_item     o_item,
    output logic          o_valid,
    output logic [OQ_IW:0] o_level
);

    t_res_item       r_mem [OQ_DEPTH];
    logic [OQ_IW:0]  r_wptr;
    logic [OQ_IW:0]  r_rptr;
    logic [OQ_IW:0]  n_wptr;
    logic [OQ_IW:0]  w_wptr1;

    // The second push lands behind the first one when both are present.
    assign w_wptr1 = i_push0.valid ? (r_wptr + 1'b1) : r_wptr;
    assign n_wptr  = w_wptr1 + {{OQ_IW{1'b0}}, i_push1.valid};

    always_ff @(posedge i_clk) begin
        if (i_push0.valid) begin
            r_mem[r_wptr[OQ_IW-1:0]] <= i_push0.item;
        end
        if (i_push1.valid) begin
            r_mem[w_wptr1[OQ_IW-1:0]] <= i_push1.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            r_wptr <= n_wptr;
            if (i_pop && o_valid) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    assign o_level = r_wptr - r_rptr;
    assign o_valid = (o_level != '0);
    assign o_item  = r_mem[r_rptr[OQ_IW-1:0]];

endmodule

>>> sv/ksc_to_ucs2_decoder.sv
// ----------------------------------------------------------------------------
// ksc_to_ucs2_decoder
// KSC-5601 / EUC-KR byte stream to 16-bit character decoder.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                          Content
// s         in   i_s_tvalid/o_s_tready/tdata/     data bytes and table loads
//                tuser/tlast
// m         out  o_m_tvalid/i_m_tready/tdata/     characters and final status
//                tlast
// cfg       in   i_cfg_we/i_cfg_idx/i_cfg_wdata   range and unmapped registers
//
// A data item passes stage one and stage two: the page index memory is read at
// the edge that accepts it, the code table memory at the edge that moves it to
// stage two, where the character and status are resolved and pushed into the
// result queue. The next data item can be taken while the first is in stage
// two, not while stage one holds one. A table write item writes its memory at
// the accepting edge. Reset is synchronous and active low; it clears the
// decoder state and the result queue at once. Both tables are undefined until
// loaded and are not cleared. o_s_tready falls while stage one holds an item
// or the queue lacks room for two more results beyond what stage two may push.
// ----------------------------------------------------------------------------
module ksc_to_ucs2_decoder
    import ksc_pkg::*;
#(
    parameter int CODE_TABLE_DEPTH = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata, lowest bit up: byte_in[7:0], out_capacity[22:8],
    // table_addr[37:23], table_word[53:38], zero pad[55:54]
    input  logic [55:0] i_s_tdata,
    // tuser, lowest bit up: req_type[1:0], first_byte[2]
    input  logic [2:0]  i_s_tuser,
    // tlast: last_byte
    input  logic        i_s_tlast,
    // Result items.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata, lowest bit up: char_code[15:0], status[17:16],
    // bytes_converted[33:18], zero pad[39:34]
    output logic [39:0] o_m_tdata,
    // tlast: is_final
    output logic        o_m_tlast,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int          AW        = $clog2(CODE_TABLE_DEPTH);
    localparam logic [16:0] DEPTH_EXT = 17'(CODE_TABLE_DEPTH);

    // Request kinds.
    localparam logic [1:0] REQ_DATA = 2'd0;
    localparam logic [1:0] REQ_PAGE = 2'd1;
    localparam logic [1:0] REQ_CODE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_CONVERT = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    // Register indexes.
    localparam logic [2:0] CFG_LEAD_LOW   = 3'd0;
    localparam logic [2:0] CFG_LEAD_HIGH  = 3'd1;
    localparam logic [2:0] CFG_TRAIL_LOW  = 3'd2;
    localparam logic [2:0] CFG_TRAIL_HIGH = 3'd3;
    localparam logic [2:0] CFG_UNMAPPABLE = 3'd4;

    // What a data item does, decided when it is accepted.
    localparam logic [2:0] K_NONE    = 3'd0;
    localparam logic [2:0] K_LOOKUP1 = 3'd1;
    localparam logic [2:0] K_LOOKUP2 = 3'd2;
    localparam logic [2:0] K_LEAD    = 3'd3;
    localparam logic [2:0] K_BAD     = 3'd4;
    localparam logic [2:0] K_TRUNC   = 3'd5;

    typedef struct packed {
        logic [7:0]  held;
        logic        pend;
        logic [14:0] room;
        logic [15:0] count;
        logic        stopped;
        logic [1:0]  status;
    } t_ctx;

    typedef struct packed {
        t_ctx        ctx;
        logic [2:0]  kind;
        logic [15:0] code;
        logic        last;
    } t_stage;

    // Input field unpacking.
    logic [1:0]  w_req;
    logic        w_first;
    logic        w_last;
    logic [7:0]  w_byte;
    logic [14:0] w_cap;
    logic [14:0] w_taddr;
    logic [15:0] w_tword;
    logic [16:0] w_taddr_ext;

    assign w_req       = i_s_tuser[1:0];
    assign w_first     = i_s_tuser[2];
    assign w_last      = i_s_tlast;
    assign w_byte      = i_s_tdata[7:0];
    assign w_cap       = i_s_tdata[22:8];
    assign w_taddr     = i_s_tdata[37:23];
    assign w_tword     = i_s_tdata[53:38];
    assign w_taddr_ext = {2'b00, w_taddr};

    // Configuration registers.
    logic [7:0]  r_lead_lo;
    logic [7:0]  r_lead_hi;
    logic [7:0]  r_trail_lo;
    logic [7:0]  r_trail_hi;
    logic [15:0] r_unmap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_lo  <= 8'hA1;
            r_lead_hi  <= 8'hFE;
            r_trail_lo <= 8'hA1;
            r_trail_hi <= 8'hFE;
            r_unmap    <= 16'h0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEAD_LOW:   r_lead_lo  <= i_cfg_wdata[7:0];
                CFG_LEAD_HIGH:  r_lead_hi  <= i_cfg_wdata[7:0];
                CFG_TRAIL_LOW:  r_trail_lo <= i_cfg_wdata[7:0];
                CFG_TRAIL_HIGH: r_trail_hi <= i_cfg_wdata[7:0];
                CFG_UNMAPPABLE: r_unmap    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Pipeline and decoder state.
    logic        w_acc;
    logic        w_acc_data;
    logic        r_s1_v;
    t_stage      r_s1;
    logic        r_s2_v;
    t_stage      r_s2;
    logic        r_s2_past;
    t_ctx        r_ctx;
    t_ctx        n_ctx;
    t_stage      w_new;
    logic [15:0] r_pi_q;
    logic [15:0] r_ct_q;
    logic [16:0] w_sum;
    logic        w_past;
    logic [AW-1:0] w_ct_raddr;
    t_push       w_push0;
    t_push       w_push1;
    logic        w_mapped;
    t_res_item   w_q_item;
    logic        w_q_valid;
    logic [OQ_IW:0] w_q_level;
    logic [OQ_IW+1:0] w_q_need;

    // Table memories.
    logic [15:0] r_page_mem [256];
    logic [15:0] r_code_mem [CODE_TABLE_DEPTH];

    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_acc_data = w_acc && (w_req == REQ_DATA);

    // Completion of the item in stage two. Its state is forwarded to the item
    // being accepted in the same cycle, so the state registers never lag.
    assign w_mapped = !r_s2_past &&
                      !((r_ct_q == r_unmap) && (r_s2.code != r_unmap));

    always_comb begin
        t_ctx c;
        c       = r_ctx;
        w_push0 = '0;
        w_push1 = '0;
        if (r_s2_v) begin
            c = r_s2.ctx;
            case (r_s2.kind)
                K_LOOKUP1, K_LOOKUP2: begin
                    if (w_mapped) begin
                        w_push0.valid          = 1'b1;
                        w_push0.item.char_code = r_ct_q;
                        c.pend  = 1'b0;
                        c.room  = c.room - 15'd1;
                        c.count = c.count + ((r_s2.kind == K_LOOKUP2) ? 16'd2 : 16'd1);
                    end else begin
                        c.status  = ST_CONVERT;
                        c.stopped = 1'b1;
                        c.pend    = 1'b0;
                    end
                end
                K_LEAD: begin
                    c.held = r_s2.code[7:0];
                    c.pend = 1'b1;
                end
                K_BAD: begin
                    c.status  = ST_BAD;
                    c.stopped = 1'b1;
                    c.pend    = 1'b0;
                end
                K_TRUNC: begin
                    c.status  = ST_TRUNC;
                    c.stopped = 1'b1;
                    c.pend    = 1'b0;
                end
                default: begin
                end
            endcase
            if (r_s2.last) begin
                // The final result follows the character, if there is one.
                if (w_push0.valid) begin
                    w_push1.valid                = 1'b1;
                    w_push1.item.is_final        = 1'b1;
                    w_push1.item.status          = c.status;
                    w_push1.item.bytes_converted = c.count;
                end else begin
                    w_push0.valid                = 1'b1;
                    w_push0.item.is_final        = 1'b1;
                    w_push0.item.status          = c.status;
                    w_push0.item.bytes_converted = c.count;
                end
                c.stopped = 1'b1;
                c.pend    = 1'b0;
            end
        end
        n_ctx = c;
    end

    // Decision for the item being accepted, taken against the forwarded state.
    always_comb begin
        t_ctx p;
        p = n_ctx;
        if (w_first) begin
            p         = '0;
            p.room    = w_cap;
            p.status  = ST_OK;
        end
        w_new.ctx  = p;
        w_new.kind = K_NONE;
        w_new.code = {8'h00, w_byte};
        w_new.last = w_last;
        if (!p.stopped) begin
            if (p.pend) begin
                if ((w_byte < r_trail_lo) || (w_byte > r_trail_hi)) begin
                    w_new.kind = K_BAD;
                end else begin
                    w_new.kind = K_LOOKUP2;
                    w_new.code = {p.held, w_byte};
                end
            end else if (p.room == 15'd0) begin
                w_new.kind = K_TRUNC;
            end else if (w_byte[7]) begin
                if ((w_byte < r_lead_lo) || (w_byte > r_lead_hi) || w_last) begin
                    w_new.kind = K_BAD;
                end else begin
                    w_new.kind = K_LEAD;
                end
            end else begin
                w_new.kind = K_LOOKUP1;
            end
        end
    end

    // Page index memory: written by table loads, read with the code's high byte.
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_req == REQ_PAGE) && (w_taddr[14:8] == 7'd0)) begin
            r_page_mem[w_taddr[7:0]] <= w_tword;
        end
        r_pi_q <= r_page_mem[w_new.code[15:8]];
    end

    // Code table memory: page base plus low code byte; past the end is flagged.
    assign w_sum      = {1'b0, r_pi_q} + {9'd0, r_s1.code[7:0]};
    assign w_past     = (w_sum >= DEPTH_EXT);
    assign w_ct_raddr = w_past ? '0 : w_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_req == REQ_CODE) && (w_taddr_ext < DEPTH_EXT)) begin
            r_code_mem[w_taddr_ext[AW-1:0]] <= w_tword;
        end
        r_ct_q <= r_code_mem[w_ct_raddr];
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (w_acc_data) begin
            r_s1 <= w_new;
        end
        if (r_s1_v) begin
            r_s2      <= r_s1;
            r_s2_past <= w_past;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_ctx  <= '0;
        end else begin
            r_s1_v <= w_acc_data;
            r_s2_v <= r_s1_v;
            r_ctx  <= n_ctx;
        end
    end

    // Take a new item only when stage one is empty and the queue keeps room for two
    // results of it on top of what the item in stage two may still push.
    assign w_q_need   = {1'b0, w_q_level} + (r_s2_v ? (OQ_IW+2)'(2) : (OQ_IW+2)'(0));
    assign o_s_tready = !r_s1_v && (w_q_need <= (OQ_IW+2)'(OQ_DEPTH - 2));

    ksc_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_push0),
        .i_push1 (w_push1),
        .i_pop   (i_m_tready),
        .o_item  (w_q_item),
        .o_valid (w_q_valid),
        .o_level (w_q_level)
    );

    assign o_m_tvalid = w_q_valid;
    assign o_m_tlast  = w_q_item.is_final;
    assign o_m_tdata  = {6'd0, w_q_item.bytes_converted, w_q_item.status,
                         w_q_item.char_code};

endmodule

>>> sv/ksc_checker.sv
// ----------------------------------------------------------------------------
// ksc_checker
// Port-level checks on the KSC decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [55:0] i_s_tdata,
    input logic [2:0]  i_s_tuser,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_idx,
    input logic [15:0] i_cfg_wdata
);

    // A waiting result stays offered until it is taken.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    // A data byte occupies the lookup pipe, so the next cycle takes nothing.
    `ASSERT_CLK(a_data_gap, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (i_s_tuser[1:0] == 2'd0) |=> !o_s_tready, "data item accepted on consecutive cycles")

    // A final result carries no character.
    `ASSERT_CLK(a_final_char, i_clk, i_rst_n, o_m_tvalid && o_m_tlast |-> (o_m_tdata[15:0] == 16'd0), "final result with a character code")

    // A character result carries neither status nor byte count.
    `ASSERT_CLK(a_char_clean, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast |-> (o_m_tdata[33:16] == 18'd0), "character result with status or count")

    // Reset empties the result queue.
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "result offered after reset")

endmodule

bind ksc_to_ucs2_decoder ksc_checker u_ksc_checker (.*);
